>>> rtl/amou_pkg.sv
// Shared types and codes for the atomic memory operation unit.
package amou_pkg;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_XOR  = 4'd1,
    CMD_OR   = 4'd2,
    CMD_AND  = 4'd3,
    CMD_MIN  = 4'd4,
    CMD_MAX  = 4'd5,
    CMD_MINU = 4'd6,
    CMD_MAXU = 4'd7,
    CMD_SWAP = 4'd8,
    CMD_LR   = 4'd9,
    CMD_SC   = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    EXC_NONE             = 3'd0,
    EXC_LOAD_MISALIGNED  = 3'd1,
    EXC_LOAD_FAULT       = 3'd2,
    EXC_STORE_MISALIGNED = 3'd3,
    EXC_STORE_FAULT      = 3'd4
  } exc_t;

  localparam logic [7:0]  WORD_STROBE  = 8'h0F;
  localparam logic [7:0]  DWORD_STROBE = 8'hFF;
  localparam logic [63:0] WORD_MASK    = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]  command;
    logic        is_double;
    logic [63:0] address;
    logic [63:0] rs2_value;
    logic [63:0] read_data;
    logic        read_error;
    logic        write_error;
    logic [63:0] program_counter;
  } req_t;

  typedef struct packed {
    logic        mem_read;
    logic        mem_write;
    logic [63:0] write_data;
    logic [7:0]  write_strobe;
    logic        rd_write;
    logic [63:0] rd_value;
    logic [2:0]  exception;
    logic [63:0] exception_value;
  } rsp_t;

endpackage

>>> rtl/amou_if.sv
// Valid/ready channel interfaces for requests and results.
interface amou_req_if;
  logic              valid;
  logic              ready;
  amou_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface amou_rsp_if;
  logic              valid;
  logic              ready;
  amou_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/atomic_memory_op_unit.sv
// Atomic memory operation unit: AMO operators, LR/SC reservation and exception checks.
//
//   channel  direction  payload       handshake
//   req      in         amou_pkg::req_t  valid/ready
//   rsp      out        amou_pkg::rsp_t  valid/ready
//
// An item is held in the input register and then moves into the result register, one
// item per cycle while rsp does not stall. An rsp stall holds the result register and
// a full input register; req.ready drops only when both are full. The reservation is
// updated as the item moves into the result register. Synchronous reset empties both
// registers and clears the reservation.
module atomic_memory_op_unit (
  input logic          clk,
  input logic          rst,
  amou_req_if.sink     req,
  amou_rsp_if.source   rsp
);

  logic           in_valid;
  amou_pkg::req_t in_item;
  logic           out_valid;
  amou_pkg::rsp_t out_item;
  logic           advance;

  logic           resv_valid;
  logic [63:0]    resv_addr;
  logic           resv_valid_next;
  logic [63:0]    resv_addr_next;

  amou_pkg::rsp_t result;
  logic           misaligned;
  logic           hit;
  logic [63:0]    loaded;
  logic [63:0]    src;
  logic [63:0]    op_result;
  logic [63:0]    wmask;
  logic [7:0]     strobe;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  always_comb begin
    misaligned = in_item.is_double ? (|in_item.address[2:0]) : (|in_item.address[1:0]);
    loaded = in_item.is_double ? in_item.read_data
                               : {{32{in_item.read_data[31]}}, in_item.read_data[31:0]};
    src = in_item.is_double ? in_item.rs2_value
                            : {{32{in_item.rs2_value[31]}}, in_item.rs2_value[31:0]};
    wmask  = in_item.is_double ? '1 : amou_pkg::WORD_MASK;
    strobe = in_item.is_double ? amou_pkg::DWORD_STROBE : amou_pkg::WORD_STROBE;
    hit    = resv_valid && (resv_addr == in_item.address);

    case (in_item.command)
      amou_pkg::CMD_ADD:  op_result = src + loaded;
      amou_pkg::CMD_XOR:  op_result = src ^ loaded;
      amou_pkg::CMD_OR:   op_result = src | loaded;
      amou_pkg::CMD_AND:  op_result = src & loaded;
      amou_pkg::CMD_MIN:  op_result = ($signed(src) < $signed(loaded)) ? src : loaded;
      amou_pkg::CMD_MAX:  op_result = ($signed(loaded) < $signed(src)) ? src : loaded;
      amou_pkg::CMD_MINU: op_result = (src < loaded) ? src : loaded;
      amou_pkg::CMD_MAXU: op_result = (src > loaded) ? src : loaded;
      default:            op_result = src;
    endcase

    result          = '0;
    resv_valid_next = resv_valid;
    resv_addr_next  = resv_addr;

    case (in_item.command) inside
      [amou_pkg::CMD_ADD:amou_pkg::CMD_SWAP]: begin
        if (misaligned) begin
          result.exception       = amou_pkg::EXC_STORE_MISALIGNED;
          result.exception_value = in_item.program_counter;
        end else begin
          result.mem_read = 1'b1;
          if (in_item.read_error) begin
            result.exception       = amou_pkg::EXC_STORE_FAULT;
            result.exception_value = in_item.address;
          end else begin
            result.mem_write    = 1'b1;
            result.write_data   = op_result & wmask;
            result.write_strobe = strobe;
            if (in_item.write_error) begin
              result.exception       = amou_pkg::EXC_STORE_FAULT;
              result.exception_value = in_item.address;
            end else begin
              result.rd_write = 1'b1;
              result.rd_value = loaded;
            end
          end
        end
      end
      amou_pkg::CMD_LR: begin
        if (misaligned) begin
          result.exception       = amou_pkg::EXC_LOAD_MISALIGNED;
          result.exception_value = in_item.program_counter;
        end else begin
          result.mem_read = 1'b1;
          if (in_item.read_error) begin
            result.exception       = amou_pkg::EXC_LOAD_FAULT;
            result.exception_value = in_item.address;
          end else begin
            resv_valid_next = 1'b1;
            resv_addr_next  = in_item.address;
            result.rd_write = 1'b1;
            result.rd_value = loaded;
          end
        end
      end
      amou_pkg::CMD_SC: begin
        // Every SC drops the reservation, whether it succeeds or not.
        resv_valid_next = 1'b0;
        if (!hit) begin
          result.rd_write = 1'b1;
          result.rd_value = 64'd1;
        end else if (misaligned) begin
          result.exception       = amou_pkg::EXC_STORE_MISALIGNED;
          result.exception_value = in_item.program_counter;
        end else begin
          result.mem_write    = 1'b1;
          result.write_data   = in_item.rs2_value & wmask;
          result.write_strobe = strobe;
          if (in_item.write_error) begin
            result.exception       = amou_pkg::EXC_STORE_FAULT;
            result.exception_value = in_item.address;
          end else begin
            result.rd_write = 1'b1;
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resv_valid <= 1'b0;
      resv_addr  <= '0;
    end else if (in_valid && advance) begin
      resv_valid <= resv_valid_next;
      resv_addr  <= resv_addr_next;
    end
  end

endmodule

>>> rtl/amou_checker.sv
// Port-level checks for the atomic memory operation unit, bound to the top level.
module amou_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input amou_pkg::rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("result item changed while stalled");

  a_strobe_matches_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.mem_write == (rsp_data.write_strobe != 8'd0)))
    else $error("write strobe disagrees with mem_write");

  a_trap_blocks_rd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.exception != amou_pkg::EXC_NONE) |-> !rsp_data.rd_write)
    else $error("rd written on an item that traps");

endmodule

bind atomic_memory_op_unit amou_checker u_amou_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

>>> bench/atomic_memory_op_unit_tb.sv
// Self-checking testbench for the atomic memory operation unit with a built-in predictor.
module atomic_memory_op_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import amou_pkg::*;

  localparam int RANDOM_ITEMS   = 430;
  localparam int LONG_STALL     = 90;
  localparam int LONG_STALL_AT  = 245;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [63:0] WORD_SIGN = 64'h0000_0000_8000_0000;

  logic clk;
  logic rst;

  amou_req_if req_ch ();
  amou_rsp_if rsp_ch ();

  atomic_memory_op_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  req_t        pending_q[$];
  int unsigned gap_q[$];
  rsp_t        due_rsp_q[$];

  // Predictor copy of the LR/SC reservation.
  logic [63:0] link_addr;
  logic        link_valid;

  int pushed_count;
  int sent_count;
  int got_count;
  int mismatches;
  int quiet_cycles;
  int rsp_hold;
  logic drv_free;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] sext_word(logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  function automatic rsp_t atomic_outcome(req_t r);
    rsp_t        o;
    logic        misal;
    logic        hit;
    logic [63:0] loaded;
    logic [63:0] src;
    logic [63:0] wmask;
    logic [63:0] combined;
    logic [7:0]  strobe;
    o = '0;
    misal = r.is_double ? (r.address[2:0] != 3'b000) : (r.address[1:0] != 2'b00);
    loaded = r.is_double ? r.read_data : sext_word(r.read_data[31:0]);
    src = r.is_double ? r.rs2_value : sext_word(r.rs2_value[31:0]);
    wmask = r.is_double ? '1 : WORD_MASK;
    strobe = r.is_double ? DWORD_STROBE : WORD_STROBE;
    if (r.command <= CMD_SWAP) begin
      if (misal) begin
        o.exception = EXC_STORE_MISALIGNED;
        o.exception_value = r.program_counter;
      end else begin
        o.mem_read = 1'b1;
        if (r.read_error) begin
          o.exception = EXC_STORE_FAULT;
          o.exception_value = r.address;
        end else begin
          case (cmd_t'(r.command))
            CMD_ADD:  combined = src + loaded;
            CMD_XOR:  combined = src ^ loaded;
            CMD_OR:   combined = src | loaded;
            CMD_AND:  combined = src & loaded;
            CMD_MIN:  combined = ($signed(src) < $signed(loaded)) ? src : loaded;
            CMD_MAX:  combined = ($signed(loaded) < $signed(src)) ? src : loaded;
            CMD_MINU: combined = (src < loaded) ? src : loaded;
            CMD_MAXU: combined = (src > loaded) ? src : loaded;
            default:  combined = src;
          endcase
          o.mem_write = 1'b1;
          o.write_data = combined & wmask;
          o.write_strobe = strobe;
          if (r.write_error) begin
            o.exception = EXC_STORE_FAULT;
            o.exception_value = r.address;
          end else begin
            o.rd_write = 1'b1;
            o.rd_value = loaded;
          end
        end
      end
    end else if (r.command == CMD_LR) begin
      if (misal) begin
        o.exception = EXC_LOAD_MISALIGNED;
        o.exception_value = r.program_counter;
      end else begin
        o.mem_read = 1'b1;
        if (r.read_error) begin
          o.exception = EXC_LOAD_FAULT;
          o.exception_value = r.address;
        end else begin
          link_addr = r.address;
          link_valid = 1'b1;
          o.rd_write = 1'b1;
          o.rd_value = loaded;
        end
      end
    end else if (r.command == CMD_SC) begin
      hit = link_valid && (link_addr == r.address);
      link_valid = 1'b0;
      if (!hit) begin
        o.rd_write = 1'b1;
        o.rd_value = 64'd1;
      end else if (misal) begin
        o.exception = EXC_STORE_MISALIGNED;
        o.exception_value = r.program_counter;
      end else begin
        o.mem_write = 1'b1;
        o.write_data = r.rs2_value & wmask;
        o.write_strobe = strobe;
        if (r.write_error) begin
          o.exception = EXC_STORE_FAULT;
          o.exception_value = r.address;
        end else begin
          o.rd_write = 1'b1;
          o.rd_value = 64'd0;
        end
      end
    end
    return o;
  endfunction

  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WORD_SIGN;
      3: return WORD_SIGN - 64'd1;
      4: return 64'h8000_0000_0000_0000;
      5: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] aligned_addr(logic dbl);
    logic [63:0] a;
    a = {$urandom, $urandom};
    a[1:0] = 2'b00;
    if (dbl) a[2] = 1'b0;
    return a;
  endfunction

  function automatic req_t build(cmd_t cmd, logic dbl, logic [63:0] addr);
    req_t r;
    r.command = cmd;
    r.is_double = dbl;
    r.address = addr;
    r.rs2_value = pick_data();
    r.read_data = pick_data();
    r.read_error = ($urandom_range(0, 9) == 0);
    r.write_error = ($urandom_range(0, 9) == 0);
    r.program_counter = pick_data();
    return r;
  endfunction

  function automatic req_t random_amo();
    logic        dbl;
    logic [63:0] a;
    dbl = 1'($urandom_range(0, 1));
    a = aligned_addr(dbl);
    if ($urandom_range(0, 9) == 0) begin
      a = {$urandom, $urandom};
      if ((dbl && a[2:0] == 3'b000) || (!dbl && a[1:0] == 2'b00)) a[0] = 1'b1;
    end
    return build(cmd_t'($urandom_range(CMD_ADD, CMD_SWAP)), dbl, a);
  endfunction

  // Each item carries the number of idle cycles the sender spends before offering it.
  task automatic queue_item(req_t r);
    pending_q.push_back(r);
    gap_q.push_back((pushed_count % 120 < 30) ? 0 : $urandom_range(0, 13));
    pushed_count++;
  endtask

  task automatic put(cmd_t cmd, logic dbl, logic [63:0] addr, logic [63:0] rs2,
                     logic [63:0] rdata, logic rerr, logic werr);
    req_t r;
    r = build(cmd, dbl, addr);
    r.rs2_value = rs2;
    r.read_data = rdata;
    r.read_error = rerr;
    r.write_error = werr;
    queue_item(r);
  endtask

  // Mostly LR/SC pairs and AMOs with random content, plus stray SCs and raw noise.
  task automatic random_sequence();
    req_t        r;
    logic [63:0] link;
    logic        dbl;
    int          kind;
    int          between;
    kind = $urandom_range(0, 99);
    dbl = 1'($urandom_range(0, 1));
    if (kind < 45) begin
      queue_item(random_amo());
    end else if (kind < 75) begin
      link = aligned_addr(dbl);
      r = build(CMD_LR, dbl, link);
      if ($urandom_range(0, 19) == 0) r.address = link | 64'd1;
      queue_item(r);
      between = $urandom_range(0, 2);
      repeat (between) queue_item(random_amo());
      if ($urandom_range(0, 99) < 15) dbl = ~dbl;
      r = build(CMD_SC, dbl, ($urandom_range(0, 4) != 0) ? link : aligned_addr(dbl));
      queue_item(r);
    end else if (kind < 90) begin
      r = build(CMD_SC, dbl, ($urandom_range(0, 1) != 0) ? link_addr : aligned_addr(dbl));
      queue_item(r);
    end else begin
      r = build(cmd_t'($urandom_range(CMD_ADD, CMD_SC)), dbl, {$urandom, $urandom});
      queue_item(r);
    end
  endtask

  // The test holds back until every item has gone through and every result is in.
  task automatic settle();
    while (sent_count != pushed_count || due_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  task automatic compare_result(rsp_t act);
    rsp_t exp;
    if (due_rsp_q.size() == 0) begin
      $display("%0t: result with nothing expected, actual %h", $time, act);
      mismatches++;
    end else begin
      exp = due_rsp_q.pop_front();
      check_field("mem_read", 64'(exp.mem_read), 64'(act.mem_read));
      check_field("mem_write", 64'(exp.mem_write), 64'(act.mem_write));
      check_field("write_data", exp.write_data, act.write_data);
      check_field("write_strobe", 64'(exp.write_strobe), 64'(act.write_strobe));
      check_field("rd_write", 64'(exp.rd_write), 64'(act.rd_write));
      check_field("rd_value", exp.rd_value, act.rd_value);
      check_field("exception", 64'(exp.exception), 64'(act.exception));
      check_field("exception_value", exp.exception_value, act.exception_value);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      drv_free = !req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        due_rsp_q.push_back(atomic_outcome(req_ch.data));
        sent_count++;
        drv_free = 1'b1;
      end
      if (drv_free) begin
        if (pending_q.size() != 0 && gap_q[0] == 0) begin
          req_ch.data <= pending_q.pop_front();
          void'(gap_q.pop_front());
          req_ch.valid <= 1'b1;
        end else begin
          if (gap_q.size() != 0) gap_q[0] = gap_q[0] - 1;
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        compare_result(rsp_ch.data);
        got_count++;
        rsp_hold = (got_count % 100 < 25) ? 0 : $urandom_range(0, 13);
        // One long hold-off so the unit fills and pushes back on the sender.
        if (got_count == LONG_STALL_AT) rsp_hold = LONG_STALL;
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL atomic_memory_op_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] base;
    int          target;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    link_addr = '0;
    link_valid = 1'b0;
    pushed_count = 0;
    sent_count = 0;
    got_count = 0;
    mismatches = 0;
    rsp_hold = 0;
    base = 64'h0000_0000_8000_1000;

    put(CMD_ADD, 1'b1, base, '1, 64'd1, 1'b0, 1'b0);
    put(CMD_ADD, 1'b0, base + 64'd4, 64'hFFFF_FFFF_7FFF_FFFF, 64'd1, 1'b0, 1'b0);
    put(CMD_XOR, 1'b1, base, 64'hA5A5_5A5A_0F0F_F0F0, '1, 1'b0, 1'b0);
    put(CMD_OR, 1'b0, base + 64'd4, 64'h1234_5678_0000_00FF, 64'hFFFF_FFFF_8000_0000,
        1'b0, 1'b0);
    put(CMD_AND, 1'b1, base, '1, 64'h8000_0000_0000_0001, 1'b0, 1'b0);
    put(CMD_MIN, 1'b0, base, WORD_SIGN, WORD_SIGN - 64'd1, 1'b0, 1'b0);
    put(CMD_MAX, 1'b0, base, WORD_SIGN, WORD_SIGN - 64'd1, 1'b0, 1'b0);
    put(CMD_MINU, 1'b0, base, WORD_SIGN, 64'd1, 1'b0, 1'b0);
    put(CMD_MAXU, 1'b1, base, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    put(CMD_MIN, 1'b1, base, 64'h8000_0000_0000_0000, '0, 1'b0, 1'b0);
    put(CMD_SWAP, 1'b0, base, 64'hDEAD_BEEF_1234_5678, '1, 1'b0, 1'b0);
    put(CMD_SWAP, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8, '1, '0, 1'b0, 1'b0);
    // Misaligned AMO, then read and write faults.
    put(CMD_ADD, 1'b0, base + 64'd2, 64'd5, 64'd7, 1'b0, 1'b0);
    put(CMD_AND, 1'b1, base, 64'd5, 64'd7, 1'b1, 1'b0);
    put(CMD_XOR, 1'b1, base, 64'd5, 64'd7, 1'b0, 1'b1);
    // SC with no reservation, then a full LR/SC pair and a repeated SC.
    put(CMD_SC, 1'b0, base, 64'd9, '0, 1'b0, 1'b0);
    put(CMD_LR, 1'b0, base, '0, 64'h1111_2222_8000_0000, 1'b0, 1'b0);
    put(CMD_SC, 1'b0, base, 64'hFFFF_FFFF_CAFE_F00D, '0, 1'b0, 1'b0);
    put(CMD_SC, 1'b0, base, 64'd9, '0, 1'b0, 1'b0);
    put(CMD_LR, 1'b1, base + 64'd1, '0, '1, 1'b0, 1'b0);
    put(CMD_LR, 1'b1, base, '0, '1, 1'b1, 1'b0);
    // A word reservation that a doubleword SC hits at a misaligned address.
    put(CMD_LR, 1'b0, base + 64'd4, '0, 64'd3, 1'b0, 1'b0);
    put(CMD_SC, 1'b1, base + 64'd4, '1, '0, 1'b0, 1'b0);
    put(CMD_LR, 1'b1, base, '0, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
    put(CMD_SC, 1'b1, base, '1, '0, 1'b0, 1'b1);
    put(CMD_LR, 1'b1, '0, '0, '1, 1'b0, 1'b0);
    put(CMD_SC, 1'b1, base, '1, '0, 1'b0, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    settle();
    target = pushed_count + RANDOM_ITEMS / 2;
    while (pushed_count < target) random_sequence();
    settle();
    target = pushed_count + RANDOM_ITEMS / 2;
    while (pushed_count < target) random_sequence();
    settle();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS atomic_memory_op_unit");
    end else begin
      $display("FAIL atomic_memory_op_unit");
    end
    $finish;
  end

endmodule
